FILE: rtl/cbs_pkg.sv
package cbs_pkg;

    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 16;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_CHECK_TICK   = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_CYCLE_TICKS  = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_LINK_TIMEOUT = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_CHARGED_DUTY = 8'd3;

    localparam logic [15:0] CHECK_TICK_RST   = 16'd1000;
    localparam logic [15:0] CYCLE_TICKS_RST  = 16'd2000;
    localparam logic [15:0] LINK_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  CHARGED_DUTY_RST = 8'h44;

    // serial link byte codes
    localparam logic [7:0] BYTE_GREET   = 8'h48;
    localparam logic [7:0] BYTE_CHARGED = 8'h42;
    localparam logic [7:0] BYTE_NOTCHG  = 8'h4E;

    localparam logic [7:0] DUTY_FULL = 8'hFF;
    localparam logic [7:0] DUTY_OFF  = 8'h00;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } cbs_in_t;

    typedef struct packed {
        logic [7:0] led_duty;
        logic       supply_5v;
        logic       send_test;
        logic       link_active;
        logic       charged;
    } cbs_out_t;

endpackage

FILE: rtl/charger_base_supervisor.sv
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_data   (cbs_in_t: req_type, rx_byte)
// m_       out        m_valid / m_ready   m_data   (cbs_out_t: duty, supply, flags)
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// Each beat is taken into the input register and is then evaluated into the
// result register, which drives m_valid; one beat per cycle is sustained
// while m_ready keeps the result register free.
// The single state update between the two registers sets the rate.
// aresetn (synchronous, active low) clears the supervisor state and loads
// the register defaults. A stalled result stalls the input register, which
// then drops s_ready; a beat is taken whenever a slot frees in that cycle.
module charger_base_supervisor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cbs_pkg::cbs_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cbs_pkg::cbs_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [cbs_pkg::CfgDataW-1:0]  cfg_data
);
    import cbs_pkg::*;

    logic [15:0] check_tick_reg;
    logic [15:0] cycle_ticks_reg;
    logic [15:0] link_timeout_reg;
    logic [7:0]  charged_duty_reg;

    logic        in_valid_reg;
    cbs_in_t     in_data_reg;
    logic        out_valid_reg;
    cbs_out_t    out_data_reg;

    logic        active_reg,       active_next;
    logic        charged_reg,      charged_next;
    logic        ramp_up_reg,      ramp_up_next;
    logic [7:0]  duty_reg,         duty_next;
    logic [15:0] timeout_cnt_reg,  timeout_cnt_next;
    logic [15:0] cycle_cnt_reg,    cycle_cnt_next;
    logic        test_supply_reg,  test_supply_next;
    logic        send_test_next;

    logic        out_free;
    logic        adv;

    assign out_free  = !out_valid_reg || m_ready;
    assign adv       = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_tick_reg   <= CHECK_TICK_RST;
            cycle_ticks_reg  <= CYCLE_TICKS_RST;
            link_timeout_reg <= LINK_TIMEOUT_RST;
            charged_duty_reg <= CHARGED_DUTY_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHECK_TICK:   check_tick_reg   <= cfg_data;
                CFG_CYCLE_TICKS:  cycle_ticks_reg  <= cfg_data;
                CFG_LINK_TIMEOUT: link_timeout_reg <= cfg_data;
                CFG_CHARGED_DUTY: charged_duty_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        active_next      = active_reg;
        charged_next     = charged_reg;
        ramp_up_next     = ramp_up_reg;
        duty_next        = duty_reg;
        timeout_cnt_next = timeout_cnt_reg;
        cycle_cnt_next   = cycle_cnt_reg;
        test_supply_next = test_supply_reg;
        send_test_next   = 1'b0;
        if (in_data_reg.req_type == REQ_BYTE) begin
            case (in_data_reg.rx_byte)
                BYTE_GREET: begin
                    if (!active_reg) begin
                        active_next  = 1'b1;
                        charged_next = 1'b0;
                        duty_next    = DUTY_FULL;
                    end
                    timeout_cnt_next = 16'd0;
                end
                BYTE_CHARGED: begin
                    charged_next     = 1'b1;
                    duty_next        = charged_duty_reg;
                    test_supply_next = 1'b0;
                end
                BYTE_NOTCHG: begin
                    charged_next     = 1'b0;
                    test_supply_next = 1'b0;
                end
                default: ;
            endcase
        end else if (active_reg) begin
            if (!charged_reg) begin
                if (ramp_up_reg) begin
                    duty_next = duty_reg + 8'd1;
                    if (duty_next == DUTY_FULL) ramp_up_next = 1'b0;
                end else begin
                    duty_next = duty_reg - 8'd1;
                    if (duty_next == DUTY_OFF) ramp_up_next = 1'b1;
                end
            end
            // test-tick match wins over end of cycle on the same tick
            cycle_cnt_next = cycle_cnt_reg + 16'd1;
            if (cycle_cnt_reg == check_tick_reg) begin
                test_supply_next = 1'b1;
                send_test_next   = 1'b1;
            end else if (cycle_cnt_reg >= cycle_ticks_reg) begin
                test_supply_next = 1'b0;
                cycle_cnt_next   = 16'd1;
            end
            timeout_cnt_next = timeout_cnt_reg + 16'd1;
            if (timeout_cnt_reg >= link_timeout_reg) begin
                duty_next        = DUTY_OFF;
                active_next      = 1'b0;
                timeout_cnt_next = 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_reg      <= 1'b0;
            charged_reg     <= 1'b0;
            ramp_up_reg     <= 1'b0;
            duty_reg        <= DUTY_OFF;
            timeout_cnt_reg <= 16'd0;
            cycle_cnt_reg   <= 16'd0;
            test_supply_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (adv) begin
                active_reg      <= active_next;
                charged_reg     <= charged_next;
                ramp_up_reg     <= ramp_up_next;
                duty_reg        <= duty_next;
                timeout_cnt_reg <= timeout_cnt_next;
                cycle_cnt_reg   <= cycle_cnt_next;
                test_supply_reg <= test_supply_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg.led_duty    <= duty_next;
            out_data_reg.supply_5v   <= test_supply_next;
            out_data_reg.send_test   <= send_test_next;
            out_data_reg.link_active <= active_next;
            out_data_reg.charged     <= charged_next;
        end
    end

    // a test request always comes with the 5 V supply; the link may time out
    // on the same tick
    a_test_supply: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.send_test) |-> m_data.supply_5v)
        else $error("send_test without 5 V supply");

    // a held input beat must block new beats
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |-> !s_ready)
        else $error("input register overwritten while stalled");

    // state moves only when a beat is evaluated
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(duty_reg) && $stable(cycle_cnt_reg)
                  && $stable(timeout_cnt_reg) && $stable(active_reg)))
        else $error("supervisor state changed without a beat");

    // a sleeping link ignores ticks
    a_sleep_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !active_reg && in_data_reg.req_type == REQ_TICK)
        |=> ($stable(duty_reg) && !active_reg))
        else $error("tick altered state while link asleep");

endmodule
